// ===== src/bas_pkg.sv =====
// shared types, constants and character helpers of the basic auth header sniffer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bas_pkg;

    localparam int RES_MAX    = 3;
    localparam int RES_CNT_W  = $clog2(RES_MAX + 1);
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // match state codes
    localparam logic [4:0] MS_SEARCH   = 5'd0;
    localparam logic [4:0] MS_CR       = 5'd1;
    localparam logic [4:0] MS_HDR0     = 5'd2;
    localparam logic [4:0] MS_HDR_LAST = 5'd22;
    localparam logic [4:0] MS_COLON    = 5'd15;
    localparam logic [4:0] MS_VALUE    = 5'd23;
    localparam logic [4:0] MS_VALUE_CR = 5'd24;

    // status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_FORMAT   = 2'd1;
    localparam logic [1:0] STS_NO_COLON = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    typedef struct packed {
        logic [4:0]  match;
        logic [1:0]  grp;
        logic [17:0] held;
        logic        pad_seen;
        logic        text_ended;
        logic        pw;
        logic        ferr;
        logic        fin;
        logic        third_pad;
    } t_state;

    typedef struct packed {
        logic       is_status;
        logic [7:0] text_byte;
        logic       in_password;
        logic [1:0] status;
        logic       last;
    } t_res;

    // header text after the line break
    function automatic logic [7:0] hdr_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = 8'h41; // A
            5'd1:    c = 8'h75; // u
            5'd2:    c = 8'h74; // t
            5'd3:    c = 8'h68; // h
            5'd4:    c = 8'h6f; // o
            5'd5:    c = 8'h72; // r
            5'd6:    c = 8'h69; // i
            5'd7:    c = 8'h7a; // z
            5'd8:    c = 8'h61; // a
            5'd9:    c = 8'h74; // t
            5'd10:   c = 8'h69; // i
            5'd11:   c = 8'h6f; // o
            5'd12:   c = 8'h6e; // n
            5'd13:   c = 8'h3a; // :
            5'd14:   c = 8'h20;
            5'd15:   c = 8'h42; // B
            5'd16:   c = 8'h61; // a
            5'd17:   c = 8'h73; // s
            5'd18:   c = 8'h69; // i
            5'd19:   c = 8'h63; // c
            5'd20:   c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // {valid, sextet}; padding reads as zero
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [6:0] r;
        r = 7'd0;
        if (ch >= 8'h41 && ch <= 8'h5a) begin
            r = {1'b1, 6'(ch - 8'h41)};
        end else if (ch >= 8'h61 && ch <= 8'h7a) begin
            r = {1'b1, 6'(ch - 8'h61 + 8'd26)};
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            r = {1'b1, 6'(ch - 8'h30 + 8'd52)};
        end else if (ch == CH_PLUS) begin
            r = {1'b1, 6'd62};
        end else if (ch == CH_SLASH) begin
            r = {1'b1, 6'd63};
        end else if (ch == CH_EQ) begin
            r = {1'b1, 6'd0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/bas_ifs.sv =====
// valid/ready channel interfaces for input beats and result beats
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface bas_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    modport source (output valid, kind, data_byte, input ready);
    modport sink (input valid, kind, data_byte, output ready);
endinterface

interface bas_out_if;
    logic       valid;
    logic       ready;
    logic       is_status;
    logic [7:0] text_byte;
    logic       in_password;
    logic [1:0] status;
    logic       last;
    modport source (output valid, is_status, text_byte, in_password, status, last,
                    input ready);
    modport sink (input valid, is_status, text_byte, in_password, status, last,
                  output ready);
endinterface

`default_nettype wire

// ===== src/basic_auth_header_sniffer_unit.sv =====
// top level of the basic auth header sniffer: input register, step logic, result queue
// depends on bas_pkg, bas_ifs, bas_step, bas_fifo
`timescale 1ns / 1ps
`default_nettype none

// Takes one stream byte per cycle while the result queue has room. A beat is
// held in an input register, then the step logic updates the match/decode state and
// writes zero to three results into an eight-entry result queue; a result leaves on
// the output channel one beat per cycle while the output is ready. Input is taken
// while the queue has room for three more results, and a new byte is taken as the
// held one advances; the first result of a byte passes the input register and the
// result queue before it appears. A kind of 1 clears all state for a new
// connection and gives no result.
module basic_auth_header_sniffer_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bas_in_if.sink     i_in,
    bas_out_if.source  o_out
);

    logic                          r_in_valid;
    logic                          r_kind;
    logic [7:0]                    r_byte;
    bas_pkg::t_state               r_state;
    bas_pkg::t_state               w_nstate;
    logic [bas_pkg::RES_CNT_W-1:0] w_cnt;
    logic [bas_pkg::RES_CNT_W-1:0] w_push_n;
    bas_pkg::t_res                 w_res [bas_pkg::RES_MAX];
    bas_pkg::t_res                 w_head;
    logic [bas_pkg::FIFO_CW-1:0]   w_count;
    logic                          w_adv;
    logic                          w_pop;

    localparam logic [bas_pkg::FIFO_CW-1:0] ROOM_LIMIT =
        bas_pkg::FIFO_CW'(bas_pkg::FIFO_DEPTH - bas_pkg::RES_MAX);

    assign w_adv      = r_in_valid && (w_count <= ROOM_LIMIT);
    assign w_push_n   = w_adv ? w_cnt : '0;
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_pop      = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_state <= w_nstate;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind <= i_in.kind;
            r_byte <= i_in.data_byte;
        end
    end

    bas_step u_step (
        .i_state (r_state),
        .i_kind  (r_kind),
        .i_ch    (r_byte),
        .o_state (w_nstate),
        .o_cnt   (w_cnt),
        .o_res   (w_res)
    );

    bas_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_din    (w_res),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_count  (w_count)
    );

    assign o_out.valid       = (w_count != '0);
    assign o_out.is_status   = w_head.is_status;
    assign o_out.text_byte   = w_head.text_byte;
    assign o_out.in_password = w_head.in_password;
    assign o_out.status      = w_head.status;
    assign o_out.last        = w_head.last;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= bas_pkg::FIFO_CW'(bas_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    a_quiet_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_state.fin && !r_kind) |-> (w_push_n == '0))
        else $error("result after final status");

    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.fin && !(w_adv && r_kind)) |=> r_state.fin)
        else $error("finished flag dropped without restart");

endmodule

`default_nettype wire

// ===== src/bas_step.sv =====
// per-byte next state and result logic: header match, base64 decode, text split
// depends on bas_pkg
`timescale 1ns / 1ps
`default_nettype none

module bas_step (
    input  wire bas_pkg::t_state             i_state,
    input  wire logic                        i_kind,
    input  wire logic [7:0]                  i_ch,
    output bas_pkg::t_state                  o_state,
    output logic [bas_pkg::RES_CNT_W-1:0]    o_cnt,
    output bas_pkg::t_res                    o_res [bas_pkg::RES_MAX]
);

    localparam logic [bas_pkg::RES_CNT_W-1:0] RES_ONE = 1;

    bas_pkg::t_state              s;
    logic [bas_pkg::RES_CNT_W-1:0] cnt;
    logic                          pre_cr;
    logic                          vc_en;
    logic                          sts_v;
    logic [1:0]                    sts_code;
    logic [6:0]                    sx;
    logic [5:0]                    a, b, c, d;
    logic [2:0]                    eb_v;
    logic [7:0]                    eb [bas_pkg::RES_MAX];
    logic [4:0]                    idx;

    always_comb begin
        s        = i_state;
        cnt      = '0;
        pre_cr   = 1'b0;
        vc_en    = 1'b0;
        sts_v    = 1'b0;
        sts_code = bas_pkg::STS_OK;
        eb_v     = 3'b000;
        sx       = bas_pkg::sextet_of(i_ch);
        a        = i_state.held[17:12];
        b        = i_state.held[11:6];
        c        = i_state.held[5:0];
        d        = sx[5:0];
        idx      = 5'(i_state.match - bas_pkg::MS_HDR0);
        for (int k = 0; k < bas_pkg::RES_MAX; k++) begin
            o_res[k] = '0;
        end
        eb[0] = {a, b[5:4]};
        eb[1] = {b[3:0], c[5:2]};
        eb[2] = {c[1:0], d};

        if (i_kind) begin
            s = '0;
        end else if (!i_state.fin) begin
            if (i_state.match == bas_pkg::MS_VALUE) begin
                if (i_ch == bas_pkg::CH_CR) begin
                    s.match = bas_pkg::MS_VALUE_CR;
                end else begin
                    vc_en = 1'b1;
                end
            end else if (i_state.match == bas_pkg::MS_VALUE_CR) begin
                if (i_ch == bas_pkg::CH_LF) begin
                    sts_v = 1'b1;
                    s.fin = 1'b1;
                    if (i_state.ferr || i_state.grp != 2'd0) begin
                        sts_code = bas_pkg::STS_FORMAT;
                    end else if (!i_state.pw) begin
                        sts_code = bas_pkg::STS_NO_COLON;
                    end
                end else begin
                    pre_cr = 1'b1;
                    if (i_ch != bas_pkg::CH_CR) begin
                        s.match = bas_pkg::MS_VALUE;
                        vc_en   = 1'b1;
                    end
                end
            end else if (i_state.match == bas_pkg::MS_CR && i_ch == bas_pkg::CH_LF) begin
                s.match = bas_pkg::MS_HDR0;
            end else if (i_state.match >= bas_pkg::MS_HDR0
                         && i_state.match <= bas_pkg::MS_HDR_LAST) begin
                if (i_ch == bas_pkg::hdr_char(idx)) begin
                    s.match = (i_state.match == bas_pkg::MS_HDR_LAST) ? bas_pkg::MS_VALUE
                                                                      : i_state.match + 5'd1;
                end else if (i_state.match > bas_pkg::MS_COLON) begin
                    s.ferr   = 1'b1;
                    s.fin    = 1'b1;
                    sts_v    = 1'b1;
                    sts_code = bas_pkg::STS_FORMAT;
                end else begin
                    s.match = (i_ch == bas_pkg::CH_CR) ? bas_pkg::MS_CR : bas_pkg::MS_SEARCH;
                end
            end else begin
                s.match = (i_ch == bas_pkg::CH_CR) ? bas_pkg::MS_CR : bas_pkg::MS_SEARCH;
            end
        end

        // held carriage return taken as a value character
        if (pre_cr && !s.ferr) begin
            if (s.pad_seen) begin
                s.grp = s.grp + 2'd1;
            end else begin
                s.ferr = 1'b1;
            end
        end

        if (vc_en && !s.ferr) begin
            if (s.pad_seen) begin
                s.grp = s.grp + 2'd1;
            end else if (!sx[6]) begin
                s.ferr = 1'b1;
            end else if (s.grp != 2'd3) begin
                if (s.grp == 2'd2) begin
                    s.third_pad = (i_ch == bas_pkg::CH_EQ);
                end
                s.held = {s.held[11:0], sx[5:0]};
                s.grp  = s.grp + 2'd1;
            end else begin
                s.grp  = 2'd0;
                s.held = '0;
                if (s.third_pad) begin
                    s.third_pad = 1'b0;
                    if (i_ch != bas_pkg::CH_EQ) begin
                        s.ferr = 1'b1;
                    end else begin
                        s.pad_seen = 1'b1;
                        eb_v       = 3'b001;
                    end
                end else if (i_ch == bas_pkg::CH_EQ) begin
                    s.pad_seen = 1'b1;
                    eb_v       = 3'b011;
                end else begin
                    eb_v = 3'b111;
                end
            end
        end

        // text split: zero ends the text, first colon switches to password
        for (int k = 0; k < bas_pkg::RES_MAX; k++) begin
            if (eb_v[k] && !s.text_ended) begin
                if (eb[k] == 8'h00) begin
                    s.text_ended = 1'b1;
                end else if (eb[k] == bas_pkg::CH_COLON && !s.pw) begin
                    s.pw = 1'b1;
                end else begin
                    o_res[cnt].text_byte   = eb[k];
                    o_res[cnt].in_password = s.pw;
                    cnt                    = cnt + 1'b1;
                end
            end
        end

        if (sts_v) begin
            o_res[0].is_status = 1'b1;
            o_res[0].status    = sts_code;
            o_res[0].last      = 1'b1;
            cnt                = RES_ONE;
        end

        o_state = s;
        o_cnt   = cnt;
    end

endmodule

`default_nettype wire

// ===== src/bas_fifo.sv =====
// result queue: up to three pushes and one pop a cycle
// depends on bas_pkg
`timescale 1ns / 1ps
`default_nettype none

module bas_fifo (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [bas_pkg::RES_CNT_W-1:0] i_push_n,
    input  wire bas_pkg::t_res                 i_din [bas_pkg::RES_MAX],
    input  wire logic                          i_pop,
    output bas_pkg::t_res                      o_head,
    output logic [bas_pkg::FIFO_CW-1:0]        o_count
);

    bas_pkg::t_res                  r_mem [bas_pkg::FIFO_DEPTH];
    logic [bas_pkg::FIFO_AW-1:0]    r_wr, n_wr;
    logic [bas_pkg::FIFO_AW-1:0]    r_rd, n_rd;
    logic [bas_pkg::FIFO_CW-1:0]    r_count, n_count;

    always_comb begin
        n_wr    = r_wr + bas_pkg::FIFO_AW'(i_push_n);
        n_rd    = r_rd + bas_pkg::FIFO_AW'(i_pop);
        n_count = r_count + bas_pkg::FIFO_CW'(i_push_n) - bas_pkg::FIFO_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < bas_pkg::RES_MAX; k++) begin
            if (bas_pkg::RES_CNT_W'(k) < i_push_n) begin
                r_mem[r_wr + bas_pkg::FIFO_AW'(k)] <= i_din[k];
            end
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== verif/tb_basic_auth_header_sniffer_unit.sv =====
// testbench of basic_auth_header_sniffer_unit: random http streams with basic auth headers
// checks every result beat against an internal predictor of the sniffer
// depends on bas_pkg, bas_ifs and the rtl of basic_auth_header_sniffer_unit
`timescale 1ns / 1ps

module tb_basic_auth_header_sniffer_unit;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_stream_beat;

    typedef logic [7:0] t_byte_q[$];

    localparam int HDR_LEN       = 21;
    localparam int HDR_COLON_POS = 13;
    localparam logic [0:HDR_LEN-1][7:0] AUTH_HDR = "Authorization: Basic ";

    logic i_clk;
    logic i_rst_n;

    bas_in_if  in_ch ();
    bas_out_if out_ch ();

    basic_auth_header_sniffer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_stream_beat    pending_beats[$];
    bas_pkg::t_res   expected_creds[$];

    // predicted sniffer state
    logic [4:0]  ms;
    logic [1:0]  grp;
    logic [17:0] held;
    bit          pad_seen;
    bit          txt_end;
    bit          pw_phase;
    bit          ferr;
    bit          fin;
    bit          third_pad;

    int beats_queued;
    int beats_taken;
    int sessions;
    int text_seen;
    int sts_count[4];
    int mismatches;

    // ---------------- predictor ----------------

    function automatic void clear_sniffer();
        ms        = bas_pkg::MS_SEARCH;
        grp       = 2'd0;
        held      = 18'd0;
        pad_seen  = 1'b0;
        txt_end   = 1'b0;
        pw_phase  = 1'b0;
        ferr      = 1'b0;
        fin       = 1'b0;
        third_pad = 1'b0;
    endfunction

    function automatic int b64_digit(logic [7:0] ch);
        if (ch >= "A" && ch <= "Z") return ch - "A";
        if (ch >= "a" && ch <= "z") return ch - "a" + 26;
        if (ch >= "0" && ch <= "9") return ch - "0" + 52;
        if (ch == bas_pkg::CH_PLUS) return 62;
        if (ch == bas_pkg::CH_SLASH) return 63;
        if (ch == bas_pkg::CH_EQ) return 0;
        return -1;
    endfunction

    function automatic void push_cred(bit st, logic [7:0] b, bit pw, logic [1:0] code, bit lst);
        bas_pkg::t_res r;
        r.is_status   = st;
        r.text_byte   = b;
        r.in_password = pw;
        r.status      = code;
        r.last        = lst;
        expected_creds.push_back(r);
    endfunction

    function automatic void emit_text(logic [7:0] b);
        if (txt_end) return;
        if (b == 8'h00) begin
            txt_end = 1'b1;
            return;
        end
        if (b == bas_pkg::CH_COLON && !pw_phase) begin
            pw_phase = 1'b1;
            return;
        end
        push_cred(1'b0, b, pw_phase, bas_pkg::STS_OK, 1'b0);
    endfunction

    function automatic void take_value_char(logic [7:0] ch);
        int v;
        logic [5:0] a, b, c, d;
        if (ferr) return;
        if (pad_seen) begin
            grp = grp + 2'd1;
            return;
        end
        v = b64_digit(ch);
        if (v < 0) begin
            ferr = 1'b1;
            return;
        end
        if (grp != 2'd3) begin
            if (grp == 2'd2) third_pad = (ch == bas_pkg::CH_EQ);
            held = {held[11:0], 6'(v)};
            grp  = grp + 2'd1;
            return;
        end
        a    = held[17:12];
        b    = held[11:6];
        c    = held[5:0];
        d    = 6'(v);
        grp  = 2'd0;
        held = 18'd0;
        if (third_pad) begin
            third_pad = 1'b0;
            if (ch != bas_pkg::CH_EQ) begin
                ferr = 1'b1;
                return;
            end
            pad_seen = 1'b1;
            emit_text({a, b[5:4]});
            return;
        end
        emit_text({a, b[5:4]});
        emit_text({b[3:0], c[5:2]});
        if (ch == bas_pkg::CH_EQ) begin
            pad_seen = 1'b1;
            return;
        end
        emit_text({c[1:0], d});
    endfunction

    function automatic void sniff_step(logic kind, logic [7:0] ch);
        int idx;
        if (kind) begin
            clear_sniffer();
            return;
        end
        if (fin) return;
        if (ms == bas_pkg::MS_VALUE) begin
            if (ch == bas_pkg::CH_CR) ms = bas_pkg::MS_VALUE_CR;
            else take_value_char(ch);
        end else if (ms == bas_pkg::MS_VALUE_CR) begin
            if (ch == bas_pkg::CH_LF) begin
                fin = 1'b1;
                if (ferr || grp != 2'd0)
                    push_cred(1'b1, 8'h00, 1'b0, bas_pkg::STS_FORMAT, 1'b1);
                else if (!pw_phase)
                    push_cred(1'b1, 8'h00, 1'b0, bas_pkg::STS_NO_COLON, 1'b1);
                else
                    push_cred(1'b1, 8'h00, 1'b0, bas_pkg::STS_OK, 1'b1);
            end else begin
                take_value_char(bas_pkg::CH_CR);
                if (ch != bas_pkg::CH_CR) begin
                    ms = bas_pkg::MS_VALUE;
                    take_value_char(ch);
                end
            end
        end else if (ms == bas_pkg::MS_CR && ch == bas_pkg::CH_LF) begin
            ms = bas_pkg::MS_HDR0;
        end else if (ms >= bas_pkg::MS_HDR0 && ms <= bas_pkg::MS_HDR_LAST) begin
            idx = ms - bas_pkg::MS_HDR0;
            if (ch == AUTH_HDR[idx]) begin
                ms = (ms == bas_pkg::MS_HDR_LAST) ? bas_pkg::MS_VALUE : ms + 5'd1;
            end else if (idx > HDR_COLON_POS) begin
                ferr = 1'b1;
                fin  = 1'b1;
                push_cred(1'b1, 8'h00, 1'b0, bas_pkg::STS_FORMAT, 1'b1);
            end else begin
                ms = (ch == bas_pkg::CH_CR) ? bas_pkg::MS_CR : bas_pkg::MS_SEARCH;
            end
        end else begin
            ms = (ch == bas_pkg::CH_CR) ? bas_pkg::MS_CR : bas_pkg::MS_SEARCH;
        end
    endfunction

    // ---------------- stream builders ----------------

    function automatic void queue_beat(logic kind, logic [7:0] b);
        t_stream_beat s;
        s.kind = kind;
        s.data = b;
        pending_beats.push_back(s);
        beats_queued++;
    endfunction

    function automatic void queue_byte(logic [7:0] b);
        queue_beat(1'b0, b);
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endfunction

    function automatic void queue_bytes(t_byte_q q);
        foreach (q[i]) queue_byte(q[i]);
    endfunction

    // line break then header, cut short by a flaw at position cut
    function automatic void queue_header(bit with_cr, int cut, logic [7:0] flaw);
        if (with_cr) queue_byte(bas_pkg::CH_CR);
        queue_byte(bas_pkg::CH_LF);
        for (int i = 0; i < HDR_LEN; i++) begin
            if (i == cut) begin
                queue_byte(flaw);
                return;
            end
            queue_byte(AUTH_HDR[i]);
        end
    endfunction

    function automatic logic [7:0] b64_char(logic [5:0] v);
        if (v < 26) return 8'h41 + v;
        if (v < 52) return 8'h61 + v - 8'd26;
        if (v < 62) return 8'h30 + v - 8'd52;
        if (v == 6'd62) return bas_pkg::CH_PLUS;
        return bas_pkg::CH_SLASH;
    endfunction

    function automatic t_byte_q b64_encode(t_byte_q raw);
        t_byte_q enc;
        logic [23:0] w;
        int n;
        n = raw.size();
        for (int i = 0; i < n; i += 3) begin
            w = {raw[i], (i + 1 < n) ? raw[i+1] : 8'h00, (i + 2 < n) ? raw[i+2] : 8'h00};
            enc.push_back(b64_char(w[23:18]));
            enc.push_back(b64_char(w[17:12]));
            enc.push_back((i + 1 < n) ? b64_char(w[11:6]) : bas_pkg::CH_EQ);
            enc.push_back((i + 2 < n) ? b64_char(w[5:0]) : bas_pkg::CH_EQ);
        end
        return enc;
    endfunction

    function automatic logic [7:0] bad_b64_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (b64_digit(c) >= 0 || c == bas_pkg::CH_CR);
        return c;
    endfunction

    function automatic logic [7:0] bad_hdr_char(int pos);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == AUTH_HDR[pos]);
        return c;
    endfunction

    function automatic logic [7:0] cred_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return bas_pkg::CH_COLON;
        if (r < 11) return 8'h00;
        if (r < 40) return 8'($urandom_range(1, 255));
        return 8'($urandom_range(8'h21, 8'h7e));
    endfunction

    // one connection: mostly a good header with random credentials, some flaws
    function automatic void queue_session();
        t_byte_q raw;
        t_byte_q chars;
        int r;
        int pos;
        logic [7:0] flaw;
        sessions++;
        queue_beat(1'b1, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3)) queue_byte(8'($urandom_range(0, 255)));
        r = $urandom_range(0, 99);
        if (r < 10) begin
            pos  = $urandom_range(0, HDR_COLON_POS);
            flaw = $urandom_range(0, 1) ? bas_pkg::CH_CR : bad_hdr_char(pos);
            queue_header(1'b1, pos, flaw);
            queue_header(flaw != bas_pkg::CH_CR, HDR_LEN, 8'h00);
        end else if (r < 16) begin
            pos = $urandom_range(HDR_COLON_POS + 1, HDR_LEN - 1);
            queue_header(1'b1, pos, bad_hdr_char(pos));
            repeat ($urandom_range(0, 3)) queue_byte(8'($urandom_range(0, 255)));
            return;
        end else begin
            queue_header(1'b1, HDR_LEN, 8'h00);
        end

        repeat ($urandom_range(0, 5)) raw.push_back(cred_char());
        if ($urandom_range(0, 9) != 0) raw.push_back(bas_pkg::CH_COLON);
        repeat ($urandom_range(0, 6)) raw.push_back(cred_char());
        chars = b64_encode(raw);

        r = $urandom_range(0, 99);
        if (r < 6 && chars.size() > 0) begin
            chars[$urandom_range(0, chars.size() - 1)] = bad_b64_char();
        end else if (r < 12) begin
            chars.insert($urandom_range(0, chars.size()), bas_pkg::CH_CR);
        end else if (r < 16 && chars.size() > 0) begin
            chars.delete($urandom_range(0, chars.size() - 1));
        end else if (r < 20 && chars.size() >= 4) begin
            pos = 4 * $urandom_range(0, chars.size() / 4 - 1);
            chars[pos + 2] = bas_pkg::CH_EQ;
        end else if (r < 24 && chars.size() >= 4) begin
            pos = 4 * $urandom_range(0, chars.size() / 4 - 1);
            chars[pos + $urandom_range(0, 1)] = bas_pkg::CH_EQ;
        end else if (r < 28) begin
            repeat ($urandom_range(1, 5))
                chars.push_back(b64_char(6'($urandom_range(0, 63))));
        end else if (r < 31) begin
            chars.delete();
        end
        queue_bytes(chars);
        queue_byte(bas_pkg::CH_CR);
        queue_byte(bas_pkg::CH_LF);
        repeat ($urandom_range(0, 2)) queue_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic int pick_pause(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ---------------- clock, driver, monitor ----------------

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = 1'b0;
        in_ch.data_byte  = 8'h00;
        out_ch.ready     = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    int           gap_left;
    bit           send_calm;
    t_stream_beat nxt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap_left = 0;
            send_calm = 1'b0;
            clear_sniffer();
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                sniff_step(in_ch.kind, in_ch.data_byte);
                beats_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    nxt = pending_beats.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.kind      <= nxt.kind;
                    in_ch.data_byte <= nxt.data;
                    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
                    gap_left = pick_pause(send_calm);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    int            stall_left;
    bit            recv_calm;
    bas_pkg::t_res want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
            recv_calm = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (out_ch.is_status) sts_count[out_ch.status]++;
                else text_seen++;
                if (expected_creds.size() == 0) begin
                    $error("unexpected result beat: is_status %0d text_byte %02h status %0d",
                           out_ch.is_status, out_ch.text_byte, out_ch.status);
                    mismatches++;
                end else begin
                    want = expected_creds.pop_front();
                    if (out_ch.is_status !== want.is_status) begin
                        $error("is_status: expected %0d, got %0d", want.is_status,
                               out_ch.is_status);
                        mismatches++;
                    end
                    if (out_ch.text_byte !== want.text_byte) begin
                        $error("text_byte: expected %02h, got %02h", want.text_byte,
                               out_ch.text_byte);
                        mismatches++;
                    end
                    if (out_ch.in_password !== want.in_password) begin
                        $error("in_password: expected %0d, got %0d", want.in_password,
                               out_ch.in_password);
                        mismatches++;
                    end
                    if (out_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_ch.status);
                        mismatches++;
                    end
                    if (out_ch.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, out_ch.last);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 59) == 0) recv_calm = !recv_calm;
                stall_left = pick_pause(recv_calm);
            end
        end
    end

    // ---------------- sequence ----------------

    task automatic drain();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || in_ch.valid || expected_creds.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // noise, a line start broken by a new cr lf, then "u:p:" in base64
        queue_beat(1'b1, 8'hff);
        queue_byte(8'h00);
        queue_byte(8'hff);
        queue_byte(bas_pkg::CH_CR);
        queue_byte(bas_pkg::CH_LF);
        queue_text("Auth");
        queue_header(1'b1, HDR_LEN, 8'h00);
        queue_text("dTpwOg==");
        queue_byte(bas_pkg::CH_CR);
        queue_byte(bas_pkg::CH_LF);
        queue_byte("x");
        // mismatch after the colon
        queue_beat(1'b1, 8'h00);
        queue_header(1'b1, 15, "b");
        // zero byte ends the text, no colon
        queue_beat(1'b1, 8'h5a);
        queue_header(1'b1, HDR_LEN, 8'h00);
        queue_text("AAA=");
        queue_byte(bas_pkg::CH_CR);
        queue_byte(bas_pkg::CH_LF);

        // hold the sender until the directed part has fully drained
        drain();

        while (beats_queued < 360) queue_session();

        drain();

        $display("run: %0d beats in over %0d random connections, %0d text beats out",
                 beats_taken, sessions, text_seen);
        $display("run: status beats ok %0d, format error %0d, no colon %0d",
                 sts_count[0], sts_count[1], sts_count[2]);
        if (mismatches == 0 && expected_creds.size() == 0) begin
            $display("basic_auth_header_sniffer_unit: match");
        end else begin
            $display("basic_auth_header_sniffer_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("basic_auth_header_sniffer_unit: mismatch");
        $finish;
    end

endmodule

// ===== basic_auth_header_sniffer_unit.f =====
src/bas_pkg.sv
src/bas_ifs.sv
src/bas_step.sv
src/bas_fifo.sv
src/basic_auth_header_sniffer_unit.sv
verif/tb_basic_auth_header_sniffer_unit.sv
